>>> rtl/core/lfuc_pkg.sv
package lfuc_pkg;

	// Default table depth and field widths
	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 32;
	localparam int VAL_W        = 32;
	localparam int CNT_W        = 32;
	localparam int TCH_W        = 64;
	localparam int CAP_REG_W    = 5;

	localparam logic [CAP_REG_W-1:0] CAP_RESET = CAP_REG_W'(16);
	localparam logic [CNT_W-1:0]     CNT_MAX   = '1;
	localparam logic [CNT_W-1:0]     CNT_ONE   = CNT_W'(1);

	// Request opcodes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Kind of entry update broadcast to the cells
	typedef enum logic {
		WR_HIT,
		WR_INSERT
	} wr_kind_t;

	// Scan record handed from cell to cell (indexes travel beside it)
	typedef struct packed {
		logic             vld;
		logic             found;
		logic [VAL_W-1:0] found_val;
		logic             have_best;
		logic [CNT_W-1:0] best_cnt;
		logic [TCH_W-1:0] best_tch;
		logic             have_free;
	} scan_t;

	// Entry update command (target index travels beside it)
	typedef struct packed {
		logic             en;
		wr_kind_t         kind;
		logic             set_val;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [TCH_W-1:0] tch;
	} wr_cmd_t;

endpackage

>>> rtl/core/lfu_cache_table.sv
// Key-value cache with least-frequently-used replacement, ties broken by
// least recent touch.
// Input channel (in_valid/in_ready): one request of opcode (get or put), key
// and value. Output channel (out_valid/out_ready): one result per request,
// hit and read_value (the value now stored on a hit, 0 on a miss).
// Configuration channel (cfg_valid/cfg_ready, always ready): cfg_data sets
// the capacity limit; 0 acts as 1, values above CAPACITY act as CAPACITY.
// Write it only while no request is in flight.
// Entries sit in a row of CAPACITY cells. A scan record walks the row one
// cell per cycle, collecting the matching entry, the eviction victim and the
// first free slot; the update is then broadcast to the target cell.
// From request accept to result valid, the scan record passes the head register,
// each cell register in row order, the collect register and the output register.
// A new request is taken only after the previous one has committed its result.
// A result waits in the output register while out_ready is low; the finished
// request holds there, and the next request is taken once it has been stored.
// Reset empties the cache, clears the touch clock and sets capacity to 16.
module lfu_cache_table #(
	parameter int CAPACITY = lfuc_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lfuc_pkg::CAP_REG_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic signed [lfuc_pkg::KEY_W-1:0] key,
	input  logic signed [lfuc_pkg::VAL_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic signed [lfuc_pkg::VAL_W-1:0] read_value
);
	import lfuc_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OW = $clog2(CAPACITY + 1);
	localparam int CW = (OW > CAP_REG_W) ? OW : CAP_REG_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [CAP_REG_W-1:0] cap_q;
	logic [OW-1:0]        occ_q;
	logic [TCH_W-1:0]     clk_tch_q;

	logic                 req_op_q;
	logic [KEY_W-1:0]     req_key_q;
	logic [VAL_W-1:0]     req_val_q;

	scan_t                head_q;
	scan_t                res_q;
	logic [IW-1:0]        res_fidx_q;
	logic [IW-1:0]        res_bidx_q;
	logic [IW-1:0]        res_free_q;

	wr_cmd_t              wr_q;
	logic [IW-1:0]        wr_idx_q;

	logic                 out_valid_q;
	logic                 hit_q;
	logic [VAL_W-1:0]     rval_q;

	scan_t                chain [CAPACITY+1];
	logic [IW-1:0]        fidx  [CAPACITY+1];
	logic [IW-1:0]        bidx  [CAPACITY+1];
	logic [IW-1:0]        fridx [CAPACITY+1];

	logic [CW-1:0]        cap_w;
	logic [CW-1:0]        eff_cap;
	logic                 full;
	logic                 do_ins;
	logic                 commit;
	logic                 accept;

	// Row of entry cells
	assign chain[0] = head_q;
	assign fidx[0]  = '0;
	assign bidx[0]  = '0;
	assign fridx[0] = '0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		lfuc_cell #(
			.IW  (IW),
			.IDX (g)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.skey        (req_key_q),
			.scan_i      (chain[g]),
			.found_idx_i (fidx[g]),
			.best_idx_i  (bidx[g]),
			.free_idx_i  (fridx[g]),
			.scan_o      (chain[g+1]),
			.found_idx_o (fidx[g+1]),
			.best_idx_o  (bidx[g+1]),
			.free_idx_o  (fridx[g+1]),
			.wr          (wr_q),
			.wr_idx      (wr_idx_q)
		);
	end

	// Clamp the capacity limit
	always_comb begin
		cap_w = CW'(cap_q);
		if (cap_w == '0) begin
			eff_cap = CW'(1);
		end else if (cap_w > CW'(CAPACITY)) begin
			eff_cap = CW'(CAPACITY);
		end else begin
			eff_cap = cap_w;
		end
	end

	assign full      = CW'(occ_q) >= eff_cap;
	assign do_ins    = !res_q.found && (req_op_q == OP_PUT);
	assign commit    = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// Hold capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Sequence one request: launch scan, collect, commit update and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			clk_tch_q   <= '0;
			req_op_q    <= OP_GET;
			req_key_q   <= '0;
			req_val_q   <= '0;
			head_q      <= '0;
			res_q       <= '0;
			res_fidx_q  <= '0;
			res_bidx_q  <= '0;
			res_free_q  <= '0;
			wr_q        <= '0;
			wr_idx_q    <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			rval_q      <= '0;
		end else begin
			head_q.vld  <= accept;
			wr_q.en     <= commit && (res_q.found || do_ins);
			out_valid_q <= commit || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chain[CAPACITY].vld) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (commit) begin
						if (res_q.found || do_ins) begin
							clk_tch_q <= clk_tch_q + TCH_W'(1);
						end
						if (do_ins && !full) begin
							occ_q <= occ_q + OW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Capture request and clear the scan record
			if (accept) begin
				req_op_q         <= opcode;
				req_key_q        <= key;
				req_val_q        <= value;
				head_q.found     <= 1'b0;
				head_q.found_val <= '0;
				head_q.have_best <= 1'b0;
				head_q.best_cnt  <= '0;
				head_q.best_tch  <= '0;
				head_q.have_free <= 1'b0;
			end
			// Collect the record at the end of the row
			if ((state_q == ST_SCAN) && chain[CAPACITY].vld) begin
				res_q      <= chain[CAPACITY];
				res_fidx_q <= fidx[CAPACITY];
				res_bidx_q <= bidx[CAPACITY];
				res_free_q <= fridx[CAPACITY];
			end
			// Load result and entry update
			if (commit) begin
				hit_q        <= res_q.found;
				rval_q       <= !res_q.found ? '0 :
					((req_op_q == OP_PUT) ? req_val_q : res_q.found_val);
				wr_q.kind    <= res_q.found ? WR_HIT : WR_INSERT;
				wr_q.set_val <= (req_op_q == OP_PUT);
				wr_q.key     <= req_key_q;
				wr_q.value   <= req_val_q;
				wr_q.tch     <= clk_tch_q + TCH_W'(1);
				wr_idx_q     <= res_q.found ? res_fidx_q : (full ? res_bidx_q : res_free_q);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = rval_q;

endmodule

>>> rtl/core/lfuc_cell.sv
module lfuc_cell #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [lfuc_pkg::KEY_W-1:0] skey,
	input  lfuc_pkg::scan_t           scan_i,
	input  logic [IW-1:0]             found_idx_i,
	input  logic [IW-1:0]             best_idx_i,
	input  logic [IW-1:0]             free_idx_i,
	output lfuc_pkg::scan_t           scan_o,
	output logic [IW-1:0]             found_idx_o,
	output logic [IW-1:0]             best_idx_o,
	output logic [IW-1:0]             free_idx_o,
	input  lfuc_pkg::wr_cmd_t         wr,
	input  logic [IW-1:0]             wr_idx
);
	import lfuc_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TCH_W-1:0] tch_q;

	scan_t            scan_q;
	logic [IW-1:0]    found_idx_q;
	logic [IW-1:0]    best_idx_q;
	logic [IW-1:0]    free_idx_q;

	logic             match;
	logic             better;
	logic             take_free;
	logic             wr_here;
	scan_t            scan_d;

	// Compare this entry against the passing scan record
	assign match     = valid_q && (key_q == skey) && !scan_i.found;
	assign better    = valid_q && (!scan_i.have_best || (cnt_q < scan_i.best_cnt) ||
		((cnt_q == scan_i.best_cnt) && (tch_q < scan_i.best_tch)));
	assign take_free = !valid_q && !scan_i.have_free;
	assign wr_here   = wr.en && (wr_idx == IW'(IDX));

	always_comb begin
		scan_d = scan_i;
		if (match) begin
			scan_d.found     = 1'b1;
			scan_d.found_val = val_q;
		end
		if (better) begin
			scan_d.have_best = 1'b1;
			scan_d.best_cnt  = cnt_q;
			scan_d.best_tch  = tch_q;
		end
		if (take_free) begin
			scan_d.have_free = 1'b1;
		end
	end

	// Hold entry valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_here && (wr.kind == WR_INSERT)) begin
			valid_q <= 1'b1;
		end
	end

	// Update entry payload on insert or hit
	always_ff @(posedge clk) begin
		if (wr_here) begin
			tch_q <= wr.tch;
			if (wr.kind == WR_INSERT) begin
				key_q <= wr.key;
				val_q <= wr.value;
				cnt_q <= CNT_ONE;
			end else begin
				if (wr.set_val) begin
					val_q <= wr.value;
				end
				if (cnt_q != CNT_MAX) begin
					cnt_q <= cnt_q + CNT_ONE;
				end
			end
		end
	end

	// Advance scan record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= scan_d;
		end
	end

	// Advance scan indexes
	always_ff @(posedge clk) begin
		found_idx_q <= match ? IW'(IDX) : found_idx_i;
		best_idx_q  <= better ? IW'(IDX) : best_idx_i;
		free_idx_q  <= take_free ? IW'(IDX) : free_idx_i;
	end

	assign scan_o      = scan_q;
	assign found_idx_o = found_idx_q;
	assign best_idx_o  = best_idx_q;
	assign free_idx_o  = free_idx_q;

endmodule
